// ----- src/mmrq_pkg.sv -----
// shared types, constants and helpers for the min/max requantizer
// no dependencies; imported by the core, the divider and the checker
package mmrq_pkg;

    localparam int CODE_BITS_W     = 4;
    localparam int CODE_W          = 8;
    localparam int STEP_W          = 24;
    localparam int FRAC_BITS       = 8;
    localparam logic [CODE_BITS_W-1:0] CODE_BITS_RESET = 4'd8;
    localparam logic [CODE_BITS_W-1:0] CODE_BITS_MAX   = 4'd8;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // 2^d - 1 with d clamped to 1..8
    function automatic logic [CODE_W-1:0] levels_of(input logic [CODE_BITS_W-1:0] cb);
        logic [CODE_W-1:0] lv;
        priority if (cb == '0)
            lv = CODE_W'(1);
        else if (cb >= CODE_BITS_MAX)
            lv = '1;
        else
            lv = (CODE_W'(1) << cb) - CODE_W'(1);
        return lv;
    endfunction

endpackage

// ----- src/minmax_requantizer_core.sv -----
// min/max linear requantizer, top level with sample store and sequencer
// depends on mmrq_pkg and mmrq_div
//
// Collects one series of signed samples, one item per cycle, into a store of
// MAX_SAMPLES entries while tracking the series minimum and maximum. The item
// marked last closes the series (a sample arriving with the store full is
// dropped and sets the dropped flag, the last one included). The block then
// stops taking items and emits one result per stored sample in arrival order:
// code = round((x-min)*(2^D-1)/(max-min)) half away from zero, the minimum as
// level_offset, and level_step = round((max-min)*256/(2^D-1)) with 8 fraction
// bits. A flat series gives all-zero codes and step. D comes from code_bits
// (0 acts as 1, above 8 acts as 8), which the user is to have written through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block itself does
// not enforce this. A run costs one step division, then per result one store
// read, one multiply and one division on the shared bit-serial divider (a
// flat series skips the division), plus any time the output is stalled.
// After the result flagged run_last is taken, the series state is cleared
// and the block accepts the next series.
module minmax_requantizer_core #(
    parameter int MAX_SAMPLES = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic                                  last,
    // result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mmrq_pkg::CODE_W-1:0]           code,
    output logic signed [SAMPLE_BITS-1:0]         level_offset,
    output logic [mmrq_pkg::STEP_W-1:0]           level_step,
    output logic                                  dropped,
    output logic                                  run_last,
    // code width register
    input  logic                                  cfg_wr_en,
    input  logic [mmrq_pkg::CODE_BITS_W-1:0]      cfg_wr_data
);
    import mmrq_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PROD_W = SAMPLE_BITS + CODE_W;
    localparam int DW     = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int VW     = SAMPLE_BITS + 1;

    // sequencer states
    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_STEP      = 3'd1;
    localparam logic [2:0] S_STEP_WAIT = 3'd2;
    localparam logic [2:0] S_READ      = 3'd3;
    localparam logic [2:0] S_MUL       = 3'd4;
    localparam logic [2:0] S_DIV       = 3'd5;
    localparam logic [2:0] S_DIV_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [IDX_W-1:0]              k_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic                          overflow_reg;
    logic [CODE_BITS_W-1:0]        code_bits_reg;

    // payload registers, no reset needed
    logic [SAMPLE_BITS-1:0]        store_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0]        rd_data_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [CODE_W-1:0]             code_reg;
    logic [STEP_W-1:0]             step_reg;

    logic                          in_acc;
    logic                          out_acc;
    logic                          has_room;
    logic                          is_final;
    logic [CODE_W-1:0]             levels;
    logic [SAMPLE_BITS-1:0]        range_w;
    logic [SAMPLE_BITS-1:0]        diff_w;

    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic [VW-1:0]                 div_divisor;
    logic [DW-1:0]                 div_quo;
    div_stat_t                     div_stat;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;
    assign has_room  = (count_reg < CNT_W'(MAX_SAMPLES));
    assign is_final  = ((CNT_W'(k_reg) + CNT_W'(1)) == count_reg);
    assign levels    = levels_of(code_bits_reg);

    // max >= min, so the true range fits SAMPLE_BITS unsigned
    assign range_w = SAMPLE_BITS'(max_reg - min_reg);
    assign diff_w  = SAMPLE_BITS'(rd_data_reg - min_reg);

    // shared divider operands: step in S_STEP, code in S_DIV
    // round half up: (2n + d) / 2d
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {range_w, FRAC_BITS'(0), 1'b0} + DW'(levels);
        div_divisor  = VW'({levels, 1'b0});
        if (state_reg == S_STEP)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_DIV)
        begin
            div_start    = (range_w != '0);
            div_dividend = {prod_reg, 1'b0} + DW'(range_w);
            div_divisor  = {range_w, 1'b0};
        end
    end

    mmrq_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // sample store
    always_ff @(posedge clk)
    begin
        if (in_acc && has_room)
            store_mem[count_reg[IDX_W-1:0]] <= sample;
        rd_data_reg <= store_mem[k_reg];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STEP_WAIT && div_stat.done)
            step_reg <= STEP_W'(div_quo);
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(diff_w) * PROD_W'(levels);
        if (state_reg == S_DIV && range_w == '0)
            code_reg <= '0;
        if (state_reg == S_DIV_WAIT && div_stat.done)
            code_reg <= CODE_W'(div_quo) & levels;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:      if (in_acc && last) state_next = S_STEP;
            S_STEP:      state_next = S_STEP_WAIT;
            S_STEP_WAIT: if (div_stat.done) state_next = S_READ;
            S_READ:      state_next = S_MUL;
            S_MUL:       state_next = S_DIV;
            S_DIV:       state_next = (range_w == '0) ? S_OUT : S_DIV_WAIT;
            S_DIV_WAIT:  if (div_stat.done) state_next = S_OUT;
            S_OUT:
            begin
                if (out_acc)
                    state_next = is_final ? S_LOAD : S_READ;
            end
            default:     state_next = S_LOAD;
        endcase
    end

    // control and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            k_reg         <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            overflow_reg  <= 1'b0;
            code_bits_reg <= CODE_BITS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                code_bits_reg <= cfg_wr_data;

            if (in_acc)
            begin
                if (has_room)
                begin
                    // first sample seeds both bounds
                    if (count_reg == '0)
                    begin
                        min_reg <= sample;
                        max_reg <= sample;
                    end
                    else if (sample < min_reg)
                        min_reg <= sample;
                    else if (sample > max_reg)
                        max_reg <= sample;
                    count_reg <= count_reg + CNT_W'(1);
                end
                else
                    overflow_reg <= 1'b1;
            end

            if (state_reg == S_STEP_WAIT)
                k_reg <= '0;

            if (out_acc)
            begin
                if (is_final)
                begin
                    // series done, clear for the next one
                    count_reg    <= '0;
                    min_reg      <= '0;
                    max_reg      <= '0;
                    overflow_reg <= 1'b0;
                    k_reg        <= '0;
                end
                else
                    k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    // result item fields
    assign code         = code_reg;
    assign level_offset = min_reg;
    assign level_step   = step_reg;
    assign dropped      = overflow_reg;
    assign run_last     = is_final;

endmodule

// ----- src/mmrq_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on mmrq_pkg (div_stat_t)
module mmrq_div #(
    parameter int DW = 25,
    parameter int VW = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DW-1:0]         dividend,
    input  logic [VW-1:0]         divisor,
    output logic [DW-1:0]         quotient,
    output mmrq_pkg::div_stat_t   stat
);
    import mmrq_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   trial;
    logic          fits;
    logic [VW:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // iteration datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits VW bits
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- src/mmrq_checker.sv -----
// port-level checks for the requantizer core, attached by bind
// depends on mmrq_pkg and minmax_requantizer_core
module mmrq_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic signed [SAMPLE_BITS-1:0]         sample,
    input logic                                  last,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [mmrq_pkg::CODE_W-1:0]           code,
    input logic signed [SAMPLE_BITS-1:0]         level_offset,
    input logic [mmrq_pkg::STEP_W-1:0]           level_step,
    input logic                                  dropped,
    input logic                                  run_last,
    input logic                                  cfg_wr_en,
    input logic [mmrq_pkg::CODE_BITS_W-1:0]      cfg_wr_data
);
    import mmrq_pkg::*;

    // loading and emitting never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output phases overlap");

    // a non-last item keeps the load phase open
    a_load_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last) |=> in_ready)
        else $error("load phase closed without a last item");

    // the last item closes the load phase
    a_last_close: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("still taking items after the last one");

    // taking the final result reopens the load phase
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && run_last) |=> (in_ready && !out_valid))
        else $error("block not back to loading after the run");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(code)
            && $stable(level_offset) && $stable(level_step)
            && $stable(dropped) && $stable(run_last)))
        else $error("stalled result changed");

endmodule

bind minmax_requantizer_core mmrq_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mmrq_checker (.*);

// ----- bench/tb_top.sv -----
// self-checking bench for minmax_requantizer_core: directed table, then random series
// depends on mmrq_pkg and the core; results are checked against an in-bench predictor
`timescale 1ns / 1ps

module tb_top;
    import mmrq_pkg::*;

    localparam int DEPTH       = 64;        // sample store entries of the core
    localparam int SAMPLE_BITS = 16;
    localparam int RAND_ITEMS  = 230;       // sample items in the random part
    localparam int GAP_PCT     = 27;        // idle cycles per hundred on each side
    localparam int SETTLE      = 40;        // quiet cycles after the last result of a run
    localparam int LIMIT       = 400000;    // cycle budget for the whole run
    localparam int REPORT_MAX  = 10;

    // one result item of the core
    typedef struct packed {
        logic [CODE_W-1:0]      code;
        logic [SAMPLE_BITS-1:0] offset;
        logic [STEP_W-1:0]      step;
        logic                   dropped;
        logic                   run_last;
    } quant_t;

    // kinds of rows in the directed table
    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    // sample mixes for the random series
    typedef enum logic [1:0] {
        SHAPE_WIDE,
        SHAPE_NARROW,
        SHAPE_FLAT,
        SHAPE_EDGES
    } series_shape_t;

    // directed row: a register write or one sample item; where typed is set, every
    // result of the series closed by this row carries the given code, offset, step and flag
    typedef struct packed {
        row_kind_t               kind;
        logic [CODE_BITS_W-1:0]  width;
        logic [SAMPLE_BITS-1:0]  smp;
        logic                    lst;
        logic                    typed;
        logic [CODE_W-1:0]       t_code;
        logic [SAMPLE_BITS-1:0]  t_offset;
        logic [STEP_W-1:0]       t_step;
        logic                    t_dropped;
    } row_t;

    localparam int NROWS = 28;
    localparam row_t PLAN [NROWS] = '{
        // width from reset (8): a lone sample is a flat series
        '{ROW_SAMPLE, 4'd0, 16'sd0,      1'b1, 1'b1, 8'd0, 16'sd0,      24'd0, 1'b0},
        // full span at 8 bits: codes 0 and 255
        '{ROW_SAMPLE, 4'd0, 16'sh8000,   1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh7fff,   1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        // flat series of three
        '{ROW_SAMPLE, 4'd0, 16'sd5,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd5,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd5,      1'b1, 1'b1, 8'd0, 16'sd5,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh7fff,   1'b1, 1'b1, 8'd0, 16'sh7fff,   24'd0, 1'b0},
        // one-bit codes, middle sample lands on a half and rounds up
        '{ROW_CFG,    4'd1, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd1,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd2,      1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh8000,   1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh7fff,   1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        // width 0 behaves as 1
        '{ROW_CFG,    4'd0, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd100,    1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, -16'sd100,   1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        // width 15 behaves as 8
        '{ROW_CFG,    4'd15, 16'sd0,     1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh7fff,   1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, -16'sd1,     1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd0,      1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        // width 9, lowest out-of-range value
        '{ROW_CFG,    4'd9, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd1,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sd2,      1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        // mid width with alternating bit patterns
        '{ROW_CFG,    4'd4, 16'sd0,      1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh5555,   1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'shaaaa,   1'b0, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0},
        '{ROW_SAMPLE, 4'd0, 16'sh8000,   1'b1, 1'b0, 8'd0, 16'sd0,      24'd0, 1'b0}
    };

    // widths for the first random phases, later phases pick at random
    localparam int NFIXED = 5;
    localparam logic [CODE_BITS_W-1:0] PHASE_WIDTH [NFIXED] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd7};

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          out_valid;
    logic                          out_ready;
    logic [CODE_W-1:0]             code;
    logic signed [SAMPLE_BITS-1:0] level_offset;
    logic [STEP_W-1:0]             level_step;
    logic                          dropped;
    logic                          run_last;
    logic                          cfg_wr_en;
    logic [CODE_BITS_W-1:0]        cfg_wr_data;

    // predictor copy of the series state and the width register
    logic signed [SAMPLE_BITS-1:0] held [DEPTH];
    int                            held_cnt;
    logic signed [SAMPLE_BITS-1:0] lo_seen;
    logic signed [SAMPLE_BITS-1:0] hi_seen;
    logic                          spilled;
    logic [CODE_BITS_W-1:0]        width_reg;

    quant_t quant_q [$];            // results still owed by the core

    quant_t seen_res;
    quant_t due_res;
    logic   no_gaps;                // stretch with no idling on either side
    int     cycle_cnt;
    int     n_items;
    int     n_series;
    int     n_checked;
    int     n_bad;

    minmax_requantizer_core #(
        .MAX_SAMPLES (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .code         (code),
        .level_offset (level_offset),
        .level_step   (level_step),
        .dropped      (dropped),
        .run_last     (run_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // predictor: folds one accepted sample into the series and, on the last one,
    // queues the full run of results; returns how many results were queued
    function automatic int absorb_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                         input logic l);
        longint lv;
        longint span;
        longint stp;
        longint num;
        longint cval;
        int     d;
        int     n;
        quant_t r;
        if (held_cnt < DEPTH)
        begin
            // the first sample seeds both bounds, later ones move at most one
            if (held_cnt == 0)
            begin
                lo_seen = s;
                hi_seen = s;
            end
            else if (s < lo_seen)
                lo_seen = s;
            else if (s > hi_seen)
                hi_seen = s;
            held[held_cnt] = s;
            held_cnt++;
        end
        else
            spilled = 1'b1;         // store full: sample lost, bounds untouched
        if (!l)
            return 0;
        // out-of-range widths fold onto 1 and 8
        d = (width_reg == 0) ? 1 : ((width_reg > 8) ? 8 : int'(width_reg));
        lv = (64'sd1 << d) - 1;
        span = longint'(hi_seen) - longint'(lo_seen);
        stp = (2 * (span << 8) + lv) / (2 * lv);
        n = held_cnt;
        for (int k = 0; k < n; k++)
        begin
            cval = 0;
            if (span != 0)
            begin
                num = (longint'(held[k]) - longint'(lo_seen)) * lv;
                cval = (2 * num + span) / (2 * span);   // half away from zero
            end
            r.code     = CODE_W'(cval & lv);
            r.offset   = lo_seen;
            r.step     = STEP_W'(stp);
            r.dropped  = spilled;
            r.run_last = (k == n - 1);
            quant_q.push_back(r);
        end
        held_cnt = 0;
        lo_seen  = '0;
        hi_seen  = '0;
        spilled  = 1'b0;
        return n;
    endfunction

    // offers one sample item, with random idle cycles ahead of it; returns at the
    // edge that accepted it, with in_valid left high for a back-to-back item
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l,
                               output int made);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        made = absorb_sample(s, l);
        n_items++;
        if (l)
            n_series++;
    endtask

    // waits until every owed result is in, then lets the core settle
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (quant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one register write, only issued while the core is idle
    task automatic write_width(input logic [CODE_BITS_W-1:0] w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    // one random series of the given length and sample mix
    task automatic feed_series(input int len, input series_shape_t shape);
        logic signed [SAMPLE_BITS-1:0] base;
        logic signed [SAMPLE_BITS-1:0] s;
        int                            made;
        base = SAMPLE_BITS'($urandom);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_WIDE:   s = SAMPLE_BITS'($urandom);
                SHAPE_NARROW: s = base + SAMPLE_BITS'($urandom_range(0, 7));
                SHAPE_FLAT:   s = base;
                default:
                begin
                    case ($urandom_range(0, 2))
                        0:       s = 16'sh8000;
                        1:       s = 16'sh7fff;
                        default: s = SAMPLE_BITS'($urandom);
                    endcase
                end
            endcase
            push_sample(s, i == len - 1, made);
        end
    endtask

    // result side: random stalls, every taken item checked against the oldest
    // expectation; the handshake is read before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_res = '{code, level_offset, level_step, dropped, run_last};
            if (quant_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= REPORT_MAX)
                    $display("unexpected result: code %0d offset %0d step %0d dropped %0b last %0b",
                             code, level_offset, level_step, dropped, run_last);
            end
            else
            begin
                due_res = quant_q.pop_front();
                n_checked++;
                if (seen_res != due_res)
                begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX)
                        $display({"mismatch at %0t: code %0d/%0d offset %0d/%0d step %0d/%0d",
                                  " dropped %0b/%0b last %0b/%0b (expected/actual)"},
                                 $realtime, due_res.code, seen_res.code,
                                 $signed(due_res.offset), $signed(seen_res.offset),
                                 due_res.step, seen_res.step, due_res.dropped,
                                 seen_res.dropped, due_res.run_last, seen_res.run_last);
                end
            end
        end
        out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still owed", LIMIT, quant_q.size());
        $display("minmax_requantizer_core regression: fail");
        $finish;
    end

    initial
    begin
        int            made;
        int            rand_fed;
        int            phase;
        int            len;
        logic          did_spill;
        series_shape_t shape;

        // every input known from time zero
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        sample      <= '0;
        last        <= 1'b0;
        out_ready   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        no_gaps     = 1'b0;
        n_items     = 0;
        n_series    = 0;
        n_checked   = 0;
        n_bad       = 0;
        held_cnt    = 0;
        lo_seen     = '0;
        hi_seen     = '0;
        spilled     = 1'b0;
        width_reg   = CODE_BITS_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows override the predicted fields of their run
        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
            begin
                wait_quiet();
                write_width(PLAN[i].width);
            end
            else
            begin
                push_sample(PLAN[i].smp, PLAN[i].lst, made);
                if (PLAN[i].typed)
                    for (int k = quant_q.size() - made; k < quant_q.size(); k++)
                    begin
                        quant_q[k].code    = PLAN[i].t_code;
                        quant_q[k].offset  = PLAN[i].t_offset;
                        quant_q[k].step    = PLAN[i].t_step;
                        quant_q[k].dropped = PLAN[i].t_dropped;
                    end
            end
        end

        // random phases: new width per phase, a few series each; phase 1 runs with
        // no idling and phase 2 carries one series that overruns the store,
        // the last sample included
        rand_fed  = 0;
        phase     = 0;
        did_spill = 1'b0;
        while (rand_fed < RAND_ITEMS)
        begin
            wait_quiet();
            write_width(phase < NFIXED ? PHASE_WIDTH[phase]
                                       : CODE_BITS_W'($urandom_range(0, 15)));
            no_gaps = (phase == 1);
            repeat ($urandom_range(2, 5))
            begin
                shape = series_shape_t'($urandom_range(0, 3));
                if (phase == 2 && !did_spill)
                begin
                    len       = DEPTH + 2;
                    did_spill = 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(9, 20);
                else
                    len = $urandom_range(1, 8);
                feed_series(len, shape);
                rand_fed += len;
            end
            phase++;
        end
        no_gaps = 1'b0;

        wait_quiet();

        $display("covered %0d sample items in %0d series over %0d width settings",
                 n_items, n_series, phase + 5);
        $display("checked %0d results, %0d failures", n_checked, n_bad);
        if (n_bad == 0 && quant_q.size() == 0)
            $display("minmax_requantizer_core regression: pass");
        else
            $display("minmax_requantizer_core regression: fail");
        $finish;
    end

endmodule
